/* design/clock_buffer_frame_replacement_macros.svh */
// Assertion macros for the frame-replacement block.
// Used by modules that include this header; expects clk and arst_n in scope.
`ifndef CLOCK_BUFFER_FRAME_REPLACEMENT_MACROS_SVH
`define CLOCK_BUFFER_FRAME_REPLACEMENT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define CBFR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CBFR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/cbfr_pkg.sv */
// Shared types and constants for the frame-replacement block.
// No dependencies.
package cbfr_pkg;

	// fixed field widths
	localparam int PAGE_W   = 16;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 3;
	localparam int FIDX_W   = 4;
	localparam int FIU_W    = 5;

	// parameter defaults
	localparam int NUM_FRAMES_DEF = 16;
	localparam int PIN_BITS_DEF   = 8;

	localparam logic [FIU_W-1:0] FIU_RESET = 5'd16;

	// operation codes
	localparam logic [OP_W-1:0] OP_ACCESS = 2'd0;
	localparam logic [OP_W-1:0] OP_UNPIN  = 2'd1;
	localparam logic [OP_W-1:0] OP_TOGGLE = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_HIT          = 3'd0;
	localparam logic [STATUS_W-1:0] ST_LOADED       = 3'd1;
	localparam logic [STATUS_W-1:0] ST_EVICT_CLEAN  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_EVICT_DIRTY  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ALL_PINNED   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_NOT_RESIDENT = 3'd5;
	localparam logic [STATUS_W-1:0] ST_DONE         = 3'd6;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_SWEEP
	} state_t;

endpackage

/* design/cbfr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cbfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* design/cbfr_table.sv */
// Frame table: RAM plus per-entry valid bits and write-to-read forwarding.
// Depends on cbfr_ram. Entries never written read as zero (empty frame).
module cbfr_table #(
	parameter int WIDTH = 26,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [DEPTH-1:0] vld_q;
	logic             vld_s1;
	logic             fwd_s1;
	logic [WIDTH-1:0] fwd_data_s1;
	logic [WIDTH-1:0] ram_q;

	cbfr_ram #(
		.WIDTH(WIDTH),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(ram_q)
	);

	// valid bits: cleared at reset, set on first write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_s1 <= vld_q[rd_addr];
				fwd_s1 <= wr_en && (wr_addr == rd_addr);
			end
		end
	end

	// forwarded data for a read that meets a write to the same entry
	always_ff @(posedge clk) begin
		if (rd_en) begin
			fwd_data_s1 <= wr_data;
		end
	end

	always_comb begin
		if (fwd_s1) begin
			rd_data = fwd_data_s1;
		end else if (vld_s1) begin
			rd_data = ram_q;
		end else begin
			rd_data = '0;
		end
	end

endmodule

/* design/clock_buffer_frame_replacement.sv */
// Buffer-pool frame table with CLOCK (second chance) replacement: top level.
// Depends on cbfr_pkg, cbfr_table, cbfr_ram and the assertion macro header.
//
//  channel   | handshake            | beat
//  ----------+----------------------+---------------------------------------
//  request   | start & !busy        | op, page_id
//  result    | done (one cycle)     | status, frame_index, victim_page
//  config    | cfg_we               | cfg_data (frames_in_use)
//
// A refused request (page 0 or OP_NONE) answers in the cycle after accept.
// Otherwise the lookup reads frames 0..n-1 from the frame RAM,
// one per cycle; a full table adds a sweep of up to 2n frame reads,
// one frame per cycle through the same RAM read port.
// Reset clears the valid bits at once, so every frame reads empty; no pass.
// The receiver cannot stall: results are shown for exactly one cycle.
module clock_buffer_frame_replacement #(
	parameter int NUM_FRAMES = cbfr_pkg::NUM_FRAMES_DEF,
	parameter int PIN_BITS   = cbfr_pkg::PIN_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [cbfr_pkg::OP_W-1:0]     op,
	input  logic [cbfr_pkg::PAGE_W-1:0]   page_id,
	output logic                          done,
	output logic [cbfr_pkg::STATUS_W-1:0] status,
	output logic [cbfr_pkg::FIDX_W-1:0]   frame_index,
	output logic [cbfr_pkg::PAGE_W-1:0]   victim_page,
	input  logic                          cfg_we,
	input  logic [cbfr_pkg::FIU_W-1:0]    cfg_data
);

	import cbfr_pkg::*;

`include "clock_buffer_frame_replacement_macros.svh"

	localparam int IDX_W = $clog2(NUM_FRAMES);
	localparam int CNT_W = $clog2(NUM_FRAMES + 1);
	localparam int STP_W = CNT_W + 1;
	localparam int ENT_W = PAGE_W + PIN_BITS + 2;

	function automatic logic [IDX_W-1:0] nxt_idx(input logic [IDX_W-1:0] h,
		input logic [CNT_W-1:0] n);
		logic [CNT_W-1:0] h1;
		h1 = CNT_W'(h) + CNT_W'(1);
		return (h1 >= n) ? '0 : h1[IDX_W-1:0];
	endfunction

	state_t              state_q, state_d;
	logic [FIU_W-1:0]    fiu_q;
	logic [CNT_W-1:0]    n_cfg, n_q;
	logic [STP_W-1:0]    n2;
	logic [OP_W-1:0]     op_q;
	logic [PAGE_W-1:0]   page_q;
	logic [STP_W-1:0]    rd_cnt_q;
	logic [STP_W-1:0]    step_q;
	logic [IDX_W-1:0]    rd_ptr_q;
	logic [IDX_W-1:0]    hand_q;
	logic [IDX_W-1:0]    hand_norm;
	logic                rdv_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic                match_found_q, empty_found_q;
	logic [IDX_W-1:0]    match_idx_q, empty_idx_q;
	logic [ENT_W-1:0]    match_data_q;

	// frame table access
	logic                rd_en, wr_en;
	logic [IDX_W-1:0]    rd_addr, wr_addr;
	logic [ENT_W-1:0]    wr_data, rd_data;

	// entry fields of the read data and of the matched entry
	logic [PAGE_W-1:0]   d_page, m_page;
	logic                d_dirty, m_dirty, d_ref;
	logic [PIN_BITS-1:0] d_pins, m_pins;
	logic [ENT_W-1:0]    install_ent;

	// decode and control
	logic                refuse;
	logic                scan_last, scan_match, scan_empty;
	logic                sweep_evict, sweep_last;
	logic                resp_d;
	logic [STATUS_W-1:0] status_d;
	logic [IDX_W-1:0]    fidx_d;
	logic [PAGE_W-1:0]   victim_d;
	logic [STATUS_W-1:0] status_q;
	logic [IDX_W-1:0]    fidx_q;
	logic [PAGE_W-1:0]   victim_q;
	logic                done_q;
	logic [IDX_W+FIDX_W-1:0] fidx_ext;

	cbfr_table #(
		.WIDTH(ENT_W),
		.DEPTH(NUM_FRAMES)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// effective frame count from the register
	always_comb begin
		if (fiu_q == '0) begin
			n_cfg = CNT_W'(1);
		end else if (32'(fiu_q) > 32'(NUM_FRAMES)) begin
			n_cfg = CNT_W'(NUM_FRAMES);
		end else begin
			n_cfg = CNT_W'(fiu_q);
		end
	end

	assign n2 = {n_q, 1'b0};

	// entry layout: page, dirty, pins, ref
	assign d_page  = rd_data[ENT_W-1 -: PAGE_W];
	assign d_dirty = rd_data[PIN_BITS+1];
	assign d_pins  = rd_data[PIN_BITS:1];
	assign d_ref   = rd_data[0];
	assign m_page  = match_data_q[ENT_W-1 -: PAGE_W];
	assign m_dirty = match_data_q[PIN_BITS+1];
	assign m_pins  = match_data_q[PIN_BITS:1];

	assign install_ent = {page_q, 1'b0, PIN_BITS'(1), 1'b1};

	assign refuse      = (page_id == '0) || (op == OP_NONE);
	assign scan_last   = rdv_s1 && (CNT_W'(idx_s1) == n_q - CNT_W'(1));
	assign scan_match  = rdv_s1 && !match_found_q && (d_page == page_q);
	assign scan_empty  = rdv_s1 && !empty_found_q && (d_page == '0);
	assign sweep_evict = rdv_s1 && (d_pins == '0) && !d_ref;
	assign sweep_last  = rdv_s1 && (step_q == n2 - STP_W'(1));
	assign hand_norm   = (CNT_W'(hand_q) >= n_q) ? '0 : hand_q;

	// next state, table access and result
	always_comb begin
		state_d  = state_q;
		rd_en    = 1'b0;
		rd_addr  = rd_cnt_q[IDX_W-1:0];
		wr_en    = 1'b0;
		wr_addr  = match_idx_q;
		wr_data  = match_data_q;
		resp_d   = 1'b0;
		status_d = ST_HIT;
		fidx_d   = '0;
		victim_d = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (refuse) begin
						resp_d   = 1'b1;
						status_d = ST_NOT_RESIDENT;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				rd_en = (rd_cnt_q < STP_W'(n_q));
				if (scan_last) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (op_q != OP_ACCESS) begin
					resp_d  = 1'b1;
					state_d = S_IDLE;
					if (!match_found_q) begin
						status_d = ST_NOT_RESIDENT;
					end else begin
						wr_en    = 1'b1;
						status_d = ST_DONE;
						fidx_d   = match_idx_q;
						if (op_q == OP_UNPIN) begin
							wr_data[PIN_BITS:1] = (m_pins != '0) ? m_pins - PIN_BITS'(1)
								: m_pins;
						end else begin
							wr_data[PIN_BITS+1] = !m_dirty;
						end
					end
				end else if (match_found_q) begin
					wr_en    = 1'b1;
					wr_data  = {m_page, m_dirty,
						(m_pins != '1) ? m_pins + PIN_BITS'(1) : m_pins, 1'b1};
					resp_d   = 1'b1;
					status_d = ST_HIT;
					fidx_d   = match_idx_q;
					state_d  = S_IDLE;
				end else if (empty_found_q) begin
					wr_en    = 1'b1;
					wr_addr  = empty_idx_q;
					wr_data  = install_ent;
					resp_d   = 1'b1;
					status_d = ST_LOADED;
					fidx_d   = empty_idx_q;
					state_d  = S_IDLE;
				end else begin
					state_d = S_SWEEP;
				end
			end
			S_SWEEP: begin
				rd_en   = (rd_cnt_q < n2);
				rd_addr = rd_ptr_q;
				wr_addr = idx_s1;
				if (sweep_evict) begin
					wr_en    = 1'b1;
					wr_data  = install_ent;
					resp_d   = 1'b1;
					status_d = d_dirty ? ST_EVICT_DIRTY : ST_EVICT_CLEAN;
					fidx_d   = idx_s1;
					victim_d = d_page;
					state_d  = S_IDLE;
				end else begin
					// unpinned frame with its ref bit set: second chance
					if (rdv_s1 && (d_pins == '0)) begin
						wr_en   = 1'b1;
						wr_data = {rd_data[ENT_W-1:1], 1'b0};
					end
					if (sweep_last) begin
						resp_d   = 1'b1;
						status_d = ST_ALL_PINNED;
						fidx_d   = hand_q;
						state_d  = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fiu_q         <= FIU_RESET;
			n_q           <= '0;
			rd_cnt_q      <= '0;
			step_q        <= '0;
			rd_ptr_q      <= '0;
			hand_q        <= '0;
			rdv_s1        <= 1'b0;
			match_found_q <= 1'b0;
			empty_found_q <= 1'b0;
			done_q        <= 1'b0;
		end else begin
			rdv_s1 <= rd_en;
			done_q <= resp_d;
			if (cfg_we) begin
				fiu_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start && !refuse) begin
						n_q           <= n_cfg;
						rd_cnt_q      <= '0;
						match_found_q <= 1'b0;
						empty_found_q <= 1'b0;
					end
				end
				S_SCAN: begin
					if (rd_en) begin
						rd_cnt_q <= rd_cnt_q + STP_W'(1);
					end
					if (scan_match) begin
						match_found_q <= 1'b1;
					end
					if (scan_empty) begin
						empty_found_q <= 1'b1;
					end
				end
				S_DECIDE: begin
					// the hand wraps only when a sweep actually begins
					if (state_d == S_SWEEP) begin
						hand_q <= hand_norm;
					end
					rd_ptr_q <= hand_norm;
					rd_cnt_q <= '0;
					step_q   <= '0;
				end
				S_SWEEP: begin
					if (rd_en) begin
						rd_ptr_q <= nxt_idx(rd_ptr_q, n_q);
						rd_cnt_q <= rd_cnt_q + STP_W'(1);
					end
					if (rdv_s1) begin
						step_q <= step_q + STP_W'(1);
					end
					if (sweep_evict) begin
						hand_q <= nxt_idx(idx_s1, n_q);
					end
				end
				default: begin
					rd_cnt_q <= '0;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_s1 <= rd_addr;
		if (state_q == S_IDLE && start) begin
			op_q   <= op;
			page_q <= page_id;
		end
		if (state_q == S_SCAN && scan_match) begin
			match_idx_q  <= idx_s1;
			match_data_q <= rd_data;
		end
		if (state_q == S_SCAN && scan_empty) begin
			empty_idx_q <= idx_s1;
		end
		if (resp_d) begin
			status_q <= status_d;
			fidx_q   <= fidx_d;
			victim_q <= victim_d;
		end
	end

	assign fidx_ext    = {FIDX_W'(0), fidx_q};
	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign frame_index = fidx_ext[FIDX_W-1:0];
	assign victim_page = victim_q;

	// a result is only shown once the block is free again
	`CBFR_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while busy")
	// an accepted request either answers at once or starts work
	`CBFR_ASSERT_NEXT(a_accept_moves, start && !busy, busy || done, "request lost")
	// same-entry read and write only in a one-frame sweep
	`CBFR_ASSERT_NOW(a_fwd_case, rd_en && wr_en && (rd_addr == wr_addr),
		(state_q == S_SWEEP) && (n_q == CNT_W'(1)), "unexpected same-entry overlap")
	// the sweep never issues more than twice the frame count
	`CBFR_ASSERT_NOW(a_sweep_bound, state_q == S_SWEEP, rd_cnt_q <= n2,
		"sweep overran its bound")

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// Testbench for the CLOCK frame-replacement block: directed and random requests,
// checked against an in-bench model of the frame table. Depends on cbfr_pkg.
module tb;
	import cbfr_pkg::*;

	localparam int NFR        = NUM_FRAMES_DEF;
	localparam int WDOG_LIMIT = 2000;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [FIDX_W-1:0]   fidx;
		logic [PAGE_W-1:0]   victim;
	} reply_t;

	// frame table model plus the queue of replies still owed by the block
	class frame_table_scoreboard;
		logic [PAGE_W-1:0]       page_of [NFR];
		logic                    dirty_of [NFR];
		logic [PIN_BITS_DEF-1:0] pins_of [NFR];
		logic                    ref_of [NFR];
		int unsigned             hand;
		logic [FIU_W-1:0]        frames;
		reply_t                  owed_replies[$];
		int unsigned             fail_count;

		function new();
			for (int i = 0; i < NFR; i++) begin
				page_of[i] = '0;
				dirty_of[i] = 1'b0;
				pins_of[i] = '0;
				ref_of[i] = 1'b0;
			end
			hand = 0;
			frames = FIU_RESET;
			fail_count = 0;
		endfunction

		function void set_frames(logic [FIU_W-1:0] v);
			frames = v;
		endfunction

		function int unsigned pending();
			return owed_replies.size();
		endfunction

		// lowest frame below n holding pg, n when none
		function int unsigned locate(logic [PAGE_W-1:0] pg, int unsigned n);
			for (int unsigned i = 0; i < n; i++)
				if (page_of[i] == pg) return i;
			return n;
		endfunction

		function void fill(int unsigned f, logic [PAGE_W-1:0] pg);
			page_of[f] = pg;
			dirty_of[f] = 1'b0;
			pins_of[f] = PIN_BITS_DEF'(1);
			ref_of[f] = 1'b1;
		endfunction

		// one accepted request beat: update the table, queue the reply
		function void note_request(logic [OP_W-1:0] op_v, logic [PAGE_W-1:0] pg);
			reply_t r;
			int unsigned n, f, h, nx;
			bit found;
			n = 32'(frames);
			if (n == 0) n = 1;
			if (n > NFR) n = NFR;
			r.status = ST_NOT_RESIDENT;
			r.fidx = '0;
			r.victim = '0;
			found = 1'b0;
			if (pg != '0 && op_v != OP_NONE) begin
				f = locate(pg, n);
				if (op_v == OP_UNPIN || op_v == OP_TOGGLE) begin
					if (f < n) begin
						if (op_v == OP_UNPIN) begin
							if (pins_of[f] != '0) pins_of[f] = pins_of[f] - 1'b1;
						end else begin
							dirty_of[f] = ~dirty_of[f];
						end
						r.status = ST_DONE;
						r.fidx = f[FIDX_W-1:0];
					end
				end else if (f < n) begin
					if (pins_of[f] != '1) pins_of[f] = pins_of[f] + 1'b1;
					ref_of[f] = 1'b1;
					r.status = ST_HIT;
					r.fidx = f[FIDX_W-1:0];
				end else begin
					f = locate('0, n);
					if (f < n) begin
						fill(f, pg);
						r.status = ST_LOADED;
						r.fidx = f[FIDX_W-1:0];
					end else begin
						// table full: second-chance sweep, bounded to two laps
						if (hand >= n) hand = 0;
						for (int unsigned s = 0; s < 2 * n && !found; s++) begin
							h = hand;
							nx = (h + 1 >= n) ? 0 : h + 1;
							if (pins_of[h] == '0) begin
								if (ref_of[h]) begin
									ref_of[h] = 1'b0;
								end else begin
									r.status = dirty_of[h] ? ST_EVICT_DIRTY : ST_EVICT_CLEAN;
									r.fidx = h[FIDX_W-1:0];
									r.victim = page_of[h];
									fill(h, pg);
									found = 1'b1;
								end
							end
							hand = nx;
						end
						if (!found) begin
							r.status = ST_ALL_PINNED;
							r.fidx = hand[FIDX_W-1:0];
						end
					end
				end
			end
			owed_replies.push_back(r);
		endfunction

		// one result beat from the block against the oldest owed reply
		function void check_reply(logic [STATUS_W-1:0] st, logic [FIDX_W-1:0] fi,
				logic [PAGE_W-1:0] vp);
			reply_t e;
			if (owed_replies.size() == 0) begin
				$error("unexpected result: status %0d frame %0d victim %0h", st, fi, vp);
				fail_count++;
				return;
			end
			e = owed_replies.pop_front();
			if (st !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, st);
				fail_count++;
			end
			if (fi !== e.fidx) begin
				$error("frame_index: expected %0d, got %0d", e.fidx, fi);
				fail_count++;
			end
			if (vp !== e.victim) begin
				$error("victim_page: expected %0h, got %0h", e.victim, vp);
				fail_count++;
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic [OP_W-1:0]     op = '0;
	logic [PAGE_W-1:0]   page_id = '0;
	logic                done;
	logic [STATUS_W-1:0] status;
	logic [FIDX_W-1:0]   frame_index;
	logic [PAGE_W-1:0]   victim_page;
	logic                cfg_we = 1'b0;
	logic [FIU_W-1:0]    cfg_data = '0;

	frame_table_scoreboard board = new();
	int unsigned idle_cycles = 0;

	clock_buffer_frame_replacement DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.page_id     (page_id),
		.done        (done),
		.status      (status),
		.frame_index (frame_index),
		.victim_page (victim_page),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data)
	);

	always #4 clk = ~clk;

	// result monitor
	always @(posedge clk) begin
		if (arst_n && done) board.check_reply(status, frame_index, victim_page);
	end

	// watchdog: too long without any beat on either side
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// drive one request beat and wait for it to be taken; start stays high
	task automatic issue(input logic [OP_W-1:0] o, input logic [PAGE_W-1:0] p);
		start <= 1'b1;
		op <= o;
		page_id <= p;
		@(posedge clk);
		while (busy) @(posedge clk);
		board.note_request(o, p);
	endtask

	// sender gap with junk on the request fields
	task automatic pause_sender(input int unsigned k);
		start <= 1'b0;
		op <= $urandom;
		page_id <= $urandom;
		repeat (k) @(posedge clk);
	endtask

	// hold off until every owed reply is in and the block is free
	task automatic drain();
		start <= 1'b0;
		while (board.pending() != 0 || busy) @(posedge clk);
	endtask

	task automatic write_frames(input logic [FIU_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_frames(v);
	endtask

	logic [PAGE_W-1:0] pool [20];
	logic [FIU_W-1:0]  plan [12];

	initial begin
		int unsigned n, psz, k, cnt;
		bit idle_on;
		logic [OP_W-1:0] o;
		logic [PAGE_W-1:0] p;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: refusals, single-frame ops, saturating unpin at zero
		issue(OP_ACCESS, 16'h0000);
		issue(OP_UNPIN, 16'h0000);
		issue(OP_TOGGLE, 16'h0000);
		issue(OP_NONE, 16'h1234);
		issue(OP_ACCESS, 16'hFFFF);
		issue(OP_ACCESS, 16'hFFFF);
		issue(OP_UNPIN, 16'hFFFF);
		issue(OP_UNPIN, 16'hFFFF);
		issue(OP_UNPIN, 16'hFFFF);
		issue(OP_TOGGLE, 16'hFFFF);
		issue(OP_TOGGLE, 16'h0001);
		issue(OP_UNPIN, 16'h0001);
		// two frames: dirty eviction, all pinned, clean eviction
		write_frames(5'd2);
		issue(OP_ACCESS, 16'h0001);
		issue(OP_ACCESS, 16'h0002);
		issue(OP_ACCESS, 16'h0003);
		issue(OP_UNPIN, 16'h0001);
		issue(OP_ACCESS, 16'h0003);
		// zero counts as one frame, over-range counts as all frames
		write_frames(5'd0);
		issue(OP_ACCESS, 16'h0004);
		issue(OP_UNPIN, 16'h0002);
		issue(OP_ACCESS, 16'h0004);
		write_frames(5'd31);
		issue(OP_ACCESS, 16'h8000);
		issue(OP_ACCESS, 16'h0001);

		// pin count saturation on a single frame
		write_frames(5'd1);
		issue(OP_UNPIN, 16'h0004);
		issue(OP_ACCESS, 16'h0005);
		for (int i = 0; i < 258; i++) issue(OP_ACCESS, 16'h0005);
		issue(OP_UNPIN, 16'h0005);
		issue(OP_ACCESS, 16'h0006);

		// random phases over a range of frame counts
		plan = '{5'd16, 5'd1, 5'd2, 5'd31, 5'd0, 5'd4, 5'd17, 5'd3, 5'd8, 5'd16, 5'd2, 5'd16};
		for (int ph = 0; ph < 12; ph++) begin
			write_frames((ph == 8) ? 5'($urandom_range(1, 16)) : plan[ph]);
			n = 32'(board.frames);
			if (n == 0) n = 1;
			if (n > NFR) n = NFR;
			psz = n + $urandom_range(1, 4);
			for (int i = 0; i < 20; i++) begin
				pool[i] = 16'($urandom_range(1, 65535));
			end
			if ($urandom_range(0, 1)) pool[0] = 16'hFFFF;
			idle_on = (ph < 10) && ($urandom_range(0, 3) != 0);
			cnt = 110 + $urandom_range(0, 20);
			for (int i = 0; i < cnt; i++) begin
				if (idle_on && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 4));
				p = pool[$urandom_range(0, psz - 1)];
				k = $urandom_range(0, 99);
				if (k < 5) begin
					o = 2'($urandom_range(0, 3));
					p = $urandom_range(0, 1) ? 16'h0000 : 16'($urandom);
				end else if (k < 8) begin
					o = OP_NONE;
				end else if (k < 52) begin
					o = OP_ACCESS;
				end else if (k < 85) begin
					o = OP_UNPIN;
				end else begin
					o = OP_TOGGLE;
				end
				issue(o, p);
			end
		end

		// let the last results arrive, then watch for strays
		drain();
		repeat (60) @(posedge clk);
		if (board.fail_count == 0 && board.pending() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
